[hw/rtl/ppcs_pkg.sv]
// Shared types and constants for the polygon plane clip stage.
`default_nettype none
package ppcs_pkg;

  localparam int CW   = 32;
  localparam int FRAC = 16;
  localparam int MW   = (CW + 1 > 32) ? CW + 1 : 32;
  localparam int DW   = ((2 * CW > CW + FRAC) ? 2 * CW : CW + FRAC) + 2;
  localparam int FMW  = 31;
  localparam int DMW  = 32;
  localparam int RW   = 33;
  localparam int CNTW = $clog2(CW + 1);

  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_D = 2'd3;
  localparam logic [1:0] LAST_COORD = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DINIT,
    OP_DMUL,
    OP_DACC,
    OP_DSAVE,
    OP_SETFIRST,
    OP_UPDATE,
    OP_CINIT,
    OP_CSHIFT,
    OP_CPREP,
    OP_LMUL,
    OP_LDVI,
    OP_LDIV,
    OP_LFIN
  } op_e;

  typedef enum logic [1:0] {
    PH_FC,
    PH_FP,
    PH_FF
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DINIT,
    S_DMUL,
    S_DACC,
    S_DSAVE,
    S_DCHK,
    S_FIRST,
    S_PCUR,
    S_UPDATE,
    S_CINIT,
    S_CSHIFT,
    S_CPREP,
    S_LMUL,
    S_LDVI,
    S_LDIV,
    S_LFIN,
    S_PCUT,
    S_FINISH
  } state_e;

  typedef struct packed {
    op_e        op;
    phase_e     phase;
    logic [1:0] coord;
    logic       emit;
    logic       emit_last;
    logic       hold_ld;
    logic       hold_cut;
  } cmd_t;

  typedef struct packed {
    logic cin;
    logic oin;
    logic fit;
    logic div_done;
    logic out_free;
    logic last;
  } stat_t;

endpackage
`default_nettype wire

[hw/rtl/ppcs_dp.sv]
// Datapath: plane registers, vertex store, distance MAC, cut-point divider, output register.
`default_nettype none
module ppcs_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [ppcs_pkg::CW-1:0]        cfg_data_i,
  input  wire logic signed [ppcs_pkg::CW-1:0] in_x_i,
  input  wire logic signed [ppcs_pkg::CW-1:0] in_y_i,
  input  wire logic signed [ppcs_pkg::CW-1:0] in_z_i,
  input  wire logic                           in_last_i,
  input  wire ppcs_pkg::cmd_t                 cmd_i,
  output ppcs_pkg::stat_t                     stat_o,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic signed [ppcs_pkg::CW-1:0]      out_x_o,
  output logic signed [ppcs_pkg::CW-1:0]      out_y_o,
  output logic signed [ppcs_pkg::CW-1:0]      out_z_o,
  output logic                                out_is_cut_o,
  output logic                                out_last_o
);

  localparam int CW   = ppcs_pkg::CW;
  localparam int MW   = ppcs_pkg::MW;
  localparam int DW   = ppcs_pkg::DW;
  localparam int FMW  = ppcs_pkg::FMW;
  localparam int DMW  = ppcs_pkg::DMW;
  localparam int RW   = ppcs_pkg::RW;
  localparam int CNTW = ppcs_pkg::CNTW;

  logic signed [CW-1:0] plane_q [4];
  logic signed [CW-1:0] cur_q   [3];
  logic signed [CW-1:0] prev_q  [3];
  logic signed [CW-1:0] first_q [3];
  logic signed [CW-1:0] held_q  [3];
  logic signed [CW-1:0] r_q     [3];
  logic                 last_q;
  logic                 held_cut_q;

  logic signed [2*MW-1:0] prod_q;
  logic signed [DW-1:0]   acc_q, fc_q, fo_q, sp_q, sq_q;
  logic [FMW-1:0]         fmag_q;
  logic [DMW-1:0]         dmag_q;
  logic                   neg_q;
  logic signed [CW-1:0]   lp_q;
  logic [RW-1:0]          rem_q;
  logic [CW-1:0]          nlo_q, quo_q;
  logic [CNTW-1:0]        dcnt_q;

  logic                 out_valid_q, out_cut_q, out_last_q;
  logic signed [CW-1:0] out_x_q, out_y_q, out_z_q;

  logic signed [CW-1:0]   vk, pk, qk;
  logic signed [CW:0]     diff;
  logic [CW:0]            mag_w;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod_c;
  logic signed [FMW-1:0]  fs, fq;
  logic signed [DMW-1:0]  den;
  logic [RW-1:0]          trial;
  logic                   ge;
  logic                   fit;

  function automatic logic fits(input logic [DW-1:0] v);
    fits = (&v[DW-1:FMW-1]) || !(|v[DW-1:FMW-1]);
  endfunction

  always_comb begin
    unique case (cmd_i.phase)
      ppcs_pkg::PH_FP: vk = prev_q[cmd_i.coord];
      ppcs_pkg::PH_FF: vk = first_q[cmd_i.coord];
      default:         vk = cur_q[cmd_i.coord];
    endcase
    if (cmd_i.phase == ppcs_pkg::PH_FF) begin
      pk = cur_q[cmd_i.coord];
      qk = first_q[cmd_i.coord];
    end else begin
      pk = prev_q[cmd_i.coord];
      qk = cur_q[cmd_i.coord];
    end
    diff  = (CW+1)'(qk) - (CW+1)'(pk);
    mag_w = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
    if (cmd_i.op == ppcs_pkg::OP_LMUL) begin
      mul_a = signed'(MW'(mag_w[CW-1:0]));
      mul_b = signed'(MW'(fmag_q));
    end else begin
      mul_a = MW'(plane_q[cmd_i.coord]);
      mul_b = MW'(vk);
    end
    fs    = sp_q[FMW-1:0];
    fq    = sq_q[FMW-1:0];
    den   = DMW'(fs) - DMW'(fq);
    trial = {rem_q[RW-2:0], nlo_q[CW-1]};
    ge    = trial >= RW'(dmag_q);
    fit   = fits(sp_q) && fits(sq_q);
  end

  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) plane_q[i] <= '0;
    end else if (cfg_we_i) begin
      plane_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ppcs_pkg::OP_LOAD: begin
        cur_q[0] <= in_x_i;
        cur_q[1] <= in_y_i;
        cur_q[2] <= in_z_i;
        last_q   <= in_last_i;
      end
      ppcs_pkg::OP_DINIT: acc_q <= DW'(plane_q[ppcs_pkg::REG_D]) <<< ppcs_pkg::FRAC;
      ppcs_pkg::OP_DMUL:  prod_q <= prod_c;
      ppcs_pkg::OP_DACC:  acc_q <= acc_q + DW'(prod_q);
      ppcs_pkg::OP_DSAVE: begin
        if (cmd_i.phase == ppcs_pkg::PH_FC) fc_q <= acc_q;
        else fo_q <= acc_q;
      end
      ppcs_pkg::OP_SETFIRST: for (int i = 0; i < 3; i++) first_q[i] <= cur_q[i];
      ppcs_pkg::OP_UPDATE:   for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
      ppcs_pkg::OP_CINIT: begin
        if (cmd_i.phase == ppcs_pkg::PH_FF) begin
          sp_q <= fc_q;
          sq_q <= fo_q;
        end else begin
          sp_q <= fo_q;
          sq_q <= fc_q;
        end
      end
      ppcs_pkg::OP_CSHIFT: begin
        if (!fit) begin
          sp_q <= sp_q >>> 1;
          sq_q <= sq_q >>> 1;
        end
      end
      ppcs_pkg::OP_CPREP: begin
        fmag_q <= fs[FMW-1] ? FMW'(-fs) : FMW'(fs);
        dmag_q <= den[DMW-1] ? DMW'(-den) : DMW'(den);
      end
      ppcs_pkg::OP_LMUL: begin
        prod_q <= prod_c;
        neg_q  <= diff[CW];
        lp_q   <= pk;
      end
      ppcs_pkg::OP_LDVI: begin
        rem_q  <= RW'(prod_q[CW+FMW-1:CW]);
        nlo_q  <= prod_q[CW-1:0];
        quo_q  <= '0;
        dcnt_q <= CNTW'(CW);
      end
      ppcs_pkg::OP_LDIV: begin
        rem_q  <= ge ? trial - RW'(dmag_q) : trial;
        quo_q  <= {quo_q[CW-2:0], ge};
        nlo_q  <= {nlo_q[CW-2:0], 1'b0};
        dcnt_q <= dcnt_q - 1'b1;
      end
      ppcs_pkg::OP_LFIN:
        r_q[cmd_i.coord] <= lp_q + CW'(neg_q ? (~quo_q + 1'b1) : quo_q);
      default: ;
    endcase
    if (cmd_i.hold_ld) begin
      for (int i = 0; i < 3; i++) held_q[i] <= cmd_i.hold_cut ? r_q[i] : cur_q[i];
      held_cut_q <= cmd_i.hold_cut;
    end
    if (cmd_i.emit) begin
      out_x_q    <= held_q[0];
      out_y_q    <= held_q[1];
      out_z_q    <= held_q[2];
      out_cut_q  <= held_cut_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.cin      = !fc_q[DW-1];
  assign stat_o.oin      = !fo_q[DW-1];
  assign stat_o.fit      = fit;
  assign stat_o.div_done = dcnt_q == CNTW'(1);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.last     = last_q;

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign out_is_cut_o = out_cut_q;
  assign out_last_o   = out_last_q;

endmodule
`default_nettype wire

[hw/rtl/ppcs_ctrl.sv]
// Controller: sequences distance, cut-point and hand-off steps for one vertex.
`default_nettype none
module ppcs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ppcs_pkg::stat_t stat_i,
  output ppcs_pkg::cmd_t       cmd_o
);

  ppcs_pkg::state_e state_q, state_d;
  ppcs_pkg::phase_e phase_q, phase_d;
  logic [1:0]       k_q, k_d;
  logic             held_valid_q, held_valid_d;
  logic             await_q, await_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ppcs_pkg::S_IDLE;
      phase_q      <= ppcs_pkg::PH_FC;
      k_q          <= '0;
      held_valid_q <= 1'b0;
      await_q      <= 1'b1;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      k_q          <= k_d;
      held_valid_q <= held_valid_d;
      await_q      <= await_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    k_d           = k_q;
    held_valid_d  = held_valid_q;
    await_d       = await_q;
    in_ready_o    = 1'b0;
    cmd_o.op        = ppcs_pkg::OP_NONE;
    cmd_o.phase     = phase_q;
    cmd_o.coord     = k_q;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_last = 1'b0;
    cmd_o.hold_ld   = 1'b0;
    cmd_o.hold_cut  = 1'b0;
    unique case (state_q)
      ppcs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ppcs_pkg::OP_LOAD;
          phase_d  = ppcs_pkg::PH_FC;
          state_d  = ppcs_pkg::S_DINIT;
        end
      end
      ppcs_pkg::S_DINIT: begin
        cmd_o.op = ppcs_pkg::OP_DINIT;
        k_d      = '0;
        state_d  = ppcs_pkg::S_DMUL;
      end
      ppcs_pkg::S_DMUL: begin
        cmd_o.op = ppcs_pkg::OP_DMUL;
        state_d  = ppcs_pkg::S_DACC;
      end
      ppcs_pkg::S_DACC: begin
        cmd_o.op = ppcs_pkg::OP_DACC;
        if (k_q == ppcs_pkg::LAST_COORD) begin
          state_d = ppcs_pkg::S_DSAVE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ppcs_pkg::S_DMUL;
        end
      end
      ppcs_pkg::S_DSAVE: begin
        cmd_o.op = ppcs_pkg::OP_DSAVE;
        state_d  = ppcs_pkg::S_DCHK;
      end
      ppcs_pkg::S_DCHK: begin
        unique case (phase_q)
          ppcs_pkg::PH_FC: begin
            if (await_q) begin
              state_d = ppcs_pkg::S_FIRST;
            end else begin
              phase_d = ppcs_pkg::PH_FP;
              state_d = ppcs_pkg::S_DINIT;
            end
          end
          ppcs_pkg::PH_FP:
            state_d = (stat_i.oin != stat_i.cin) ? ppcs_pkg::S_CINIT : ppcs_pkg::S_PCUR;
          ppcs_pkg::PH_FF:
            state_d = (stat_i.oin != stat_i.cin) ? ppcs_pkg::S_CINIT : ppcs_pkg::S_FINISH;
          default: state_d = ppcs_pkg::S_IDLE;
        endcase
      end
      ppcs_pkg::S_FIRST: begin
        cmd_o.op = ppcs_pkg::OP_SETFIRST;
        await_d  = 1'b0;
        state_d  = ppcs_pkg::S_PCUR;
      end
      ppcs_pkg::S_PCUR: begin
        if (!stat_i.cin) begin
          state_d = ppcs_pkg::S_UPDATE;
        end else if (!held_valid_q || stat_i.out_free) begin
          cmd_o.hold_ld = 1'b1;
          cmd_o.emit    = held_valid_q;
          held_valid_d  = 1'b1;
          state_d       = ppcs_pkg::S_UPDATE;
        end
      end
      ppcs_pkg::S_UPDATE: begin
        cmd_o.op = ppcs_pkg::OP_UPDATE;
        if (stat_i.last) begin
          phase_d = ppcs_pkg::PH_FF;
          state_d = ppcs_pkg::S_DINIT;
        end else begin
          state_d = ppcs_pkg::S_IDLE;
        end
      end
      ppcs_pkg::S_CINIT: begin
        cmd_o.op = ppcs_pkg::OP_CINIT;
        state_d  = ppcs_pkg::S_CSHIFT;
      end
      ppcs_pkg::S_CSHIFT: begin
        if (stat_i.fit) state_d = ppcs_pkg::S_CPREP;
        else cmd_o.op = ppcs_pkg::OP_CSHIFT;
      end
      ppcs_pkg::S_CPREP: begin
        cmd_o.op = ppcs_pkg::OP_CPREP;
        k_d      = '0;
        state_d  = ppcs_pkg::S_LMUL;
      end
      ppcs_pkg::S_LMUL: begin
        cmd_o.op = ppcs_pkg::OP_LMUL;
        state_d  = ppcs_pkg::S_LDVI;
      end
      ppcs_pkg::S_LDVI: begin
        cmd_o.op = ppcs_pkg::OP_LDVI;
        state_d  = ppcs_pkg::S_LDIV;
      end
      ppcs_pkg::S_LDIV: begin
        cmd_o.op = ppcs_pkg::OP_LDIV;
        if (stat_i.div_done) state_d = ppcs_pkg::S_LFIN;
      end
      ppcs_pkg::S_LFIN: begin
        cmd_o.op = ppcs_pkg::OP_LFIN;
        if (k_q == ppcs_pkg::LAST_COORD) begin
          state_d = ppcs_pkg::S_PCUT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ppcs_pkg::S_LMUL;
        end
      end
      ppcs_pkg::S_PCUT: begin
        if (!held_valid_q || stat_i.out_free) begin
          cmd_o.hold_ld  = 1'b1;
          cmd_o.hold_cut = 1'b1;
          cmd_o.emit     = held_valid_q;
          held_valid_d   = 1'b1;
          state_d = (phase_q == ppcs_pkg::PH_FP) ? ppcs_pkg::S_PCUR : ppcs_pkg::S_FINISH;
        end
      end
      ppcs_pkg::S_FINISH: begin
        if (!held_valid_q) begin
          await_d = 1'b1;
          state_d = ppcs_pkg::S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          held_valid_d    = 1'b0;
          await_d         = 1'b1;
          state_d         = ppcs_pkg::S_IDLE;
        end
      end
      default: state_d = ppcs_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/polygon_plane_clip_stage_core.sv]
// Top level of the single-plane polygon clip stage.
// Vertices enter on the in_ channel (valid/ready), one request per vertex,
// in_last_i on the final vertex of a polygon. Clipped vertices leave on the
// out_ channel; out_is_cut_o marks intersection points, out_last_o the final
// vertex of the clipped polygon. The user must write the plane (a, b, c, d)
// through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle; the
// block does not enforce this. One vertex at a time is processed.
// A vertex without a crossing computes two plane distances (one when it
// starts a polygon). Each crossing edge adds the range-reduction shift plus
// the three interpolated coordinates, each from the restoring divider that
// yields one quotient bit per cycle. A closing vertex adds one more distance.
// Each result is held back one step so out_last_o can be placed; results leave
// through a single output register. If the receiver stalls, the sequencer
// waits at its next hand-off and stops taking vertices.
// Reset clears the plane to zero, empties the output and starts a new polygon.
`default_nettype none
module polygon_plane_clip_stage_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [ppcs_pkg::CW-1:0]        cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [ppcs_pkg::CW-1:0] in_x_i,
  input  wire logic signed [ppcs_pkg::CW-1:0] in_y_i,
  input  wire logic signed [ppcs_pkg::CW-1:0] in_z_i,
  input  wire logic                           in_last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [ppcs_pkg::CW-1:0]      out_x_o,
  output logic signed [ppcs_pkg::CW-1:0]      out_y_o,
  output logic signed [ppcs_pkg::CW-1:0]      out_z_o,
  output logic                                out_is_cut_o,
  output logic                                out_last_o
);

  ppcs_pkg::cmd_t  cmd;
  ppcs_pkg::stat_t stat;

  ppcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ppcs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_x_i       (in_x_i),
    .in_y_i       (in_y_i),
    .in_z_i       (in_z_i),
    .in_last_i    (in_last_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_is_cut_o (out_is_cut_o),
    .out_last_o   (out_last_o)
  );

endmodule
`default_nettype wire

[hw/rtl/ppcs_chk.sv]
// Port-level checker for the clip stage, bound to the top level.
`default_nettype none
module ppcs_chk (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic [ppcs_pkg::CW-1:0] out_x_o,
  input wire logic                    out_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(out_last_o))
    else $error("output request dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && in_ready_o)
    else $error("output valid or input blocked during reset");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new vertex taken while previous one still in work");

endmodule

bind polygon_plane_clip_stage_core ppcs_chk u_ppcs_chk (.*);
`default_nettype wire
